### hdl/tssr_pkg.sv
// Shared types, constants and helper functions for the tile and sprite scanline renderer.
package tssr_pkg;

  localparam int unsigned ObjPerLine  = 10;
  localparam int unsigned ObjCount    = 40;
  localparam int unsigned ScreenWidth = 160;
  localparam int unsigned VideoBytes  = 8192;
  localparam int unsigned OamBytes    = 160;
  localparam int unsigned WinLines    = 144;

  localparam int unsigned VaW   = $clog2(VideoBytes);
  localparam int unsigned OaW   = $clog2(OamBytes);
  localparam int unsigned SlotW = $clog2(ObjPerLine + 1);
  localparam int unsigned ObjW  = $clog2(ObjCount);

  typedef enum logic [1:0] {
    OP_VRAM_WR = 2'd0,
    OP_OAM_WR  = 2'd1,
    OP_LINE    = 2'd2,
    OP_PIXEL   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_LCDC  = 3'd0,
    CFG_SCY   = 3'd1,
    CFG_SCX   = 3'd2,
    CFG_WY    = 3'd3,
    CFG_WX    = 3'd4,
    CFG_BGP   = 3'd5,
    CFG_OBP0  = 3'd6,
    CFG_OBP1  = 3'd7
  } cfg_e;

  typedef struct packed {
    logic [7:0]  x;
    logic [7:0]  attr;
    logic [15:0] pattern;
  } obj_t;

  function automatic logic [1:0] pick_index(logic [15:0] d, logic [2:0] tx);
    pick_index = {d[{1'b1, ~tx}], d[{1'b0, ~tx}]};
  endfunction

  function automatic logic [1:0] pal_map(logic [7:0] p, logic [1:0] idx);
    pal_map = {p[{idx, 1'b1}], p[{idx, 1'b0}]};
  endfunction

  function automatic logic [7:0] rev_byte(logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = b[i];
    end
    rev_byte = r;
  endfunction

endpackage

### hdl/tssr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tssr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### hdl/tile_sprite_scanline_renderer.sv
// Top level: sequencer around the video and object memories for one scanline renderer.
// Usage: a memory write is taken while idle and leaves the block idle; any other beat keeps
// it busy. A pixel steps through R_START, R_WIN (and R_WSEL inside the window), R_OBJI, one
// R_OBJ per object kept on the line when objects are on, and R_FIN, plus a tile row fetch
// (F_MAP to F_HI) for each background or window tile it needs (at most two per pixel); with
// the display off it goes straight from R_START to R_FIN. A line start reads 4 object bytes
// per object scanned and 2 pattern bytes per object kept, then runs an exchange sort of up
// to 10 entries. Everything runs through the single read port of each memory, under one state
// machine; the result sits in an output register so the next beat can be taken while it waits.
module tile_sprite_scanline_renderer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [7:0]            cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            op_i,
  input  logic [12:0]           address_i,
  input  logic [7:0]            write_data_i,
  input  logic [7:0]            line_number_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            shade_o,
  output logic [7:0]            column_o,
  output logic [7:0]            row_o
);
  import tssr_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, SC_A0, SC_A1, SC_Y, SC_X, SC_T, SC_AT, SC_CHK, SC_P0, SC_P1, SC_P2,
    SO_INIT, SO_LOAD, SO_CMP, SO_STORE,
    R_START, R_WIN, R_WSEL, R_OBJI, R_OBJ, R_FIN,
    F_MAP, F_MW, F_TILE, F_DW, F_LO, F_HI
  } state_e;

  state_e state_q;

  logic [7:0] lcdc_q, scy_q, scx_q, wy_q, wx_q, bgp_q, obp0_q, obp1_q;

  logic [7:0]  col_q, ly_q;
  logic [15:0] bg_latch_q, win_latch_q;
  logic [SlotW-1:0] cnt_q, lo_q, hi_q, n_q;
  logic [ObjW-1:0]  obj_q;
  logic [OaW-1:0]   oa_q;
  logic [VaW-1:0]   va_q;
  logic [7:0] oy_q, ox_q, ot_q, oat_q, plo_q;
  obj_t cur_q;
  logic [7:0] fx_q, fy_q;
  logic       fhm_q, fwin_q, dark_q;
  logic [1:0] bi_q, oi_q;
  logic [7:0] oattr_q;
  logic       out_valid_q;
  logic [1:0] shade_q;
  logic [7:0] ocol_q, orow_q;

  obj_t line_q [ObjPerLine];
  logic             lw_we;
  logic [SlotW-1:0] lw_idx, lr_idx;
  obj_t             lw_data, lr_data;

  logic       accept;
  logic [7:0] vram_rd, oam_rd;

  assign accept     = in_valid_i & in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  tssr_ram #(.Width(8), .Depth(VideoBytes)) u_vram (
    .clk_i   (clk_i),
    .we_i    (accept && (op_i == OP_VRAM_WR)),
    .waddr_i (address_i),
    .wdata_i (write_data_i),
    .raddr_i (va_q),
    .rdata_o (vram_rd)
  );

  tssr_ram #(.Width(8), .Depth(OamBytes)) u_oam (
    .clk_i   (clk_i),
    .we_i    (accept && (op_i == OP_OAM_WR) && (address_i < 13'(OamBytes))),
    .waddr_i (address_i[OaW-1:0]),
    .wdata_i (write_data_i),
    .raddr_i (oa_q),
    .rdata_o (oam_rd)
  );

  // pixel geometry
  logic [7:0] sx, sy, wxv, wyv;
  logic [8:0] pxp7, pxp8;
  logic       win_hit;
  assign sx   = col_q + scx_q;
  assign sy   = ly_q + scy_q;
  assign pxp7 = {1'b0, col_q} + 9'd7;
  assign pxp8 = {1'b0, col_q} + 9'd8;
  assign wyv  = ly_q - wy_q;
  assign wxv  = 8'(pxp7 - {1'b0, wx_q});
  assign win_hit = lcdc_q[5] && (ly_q >= wy_q) && ({1'b0, wyv} < 9'(WinLines)) &&
                   (pxp7 >= {1'b0, wx_q}) && ((pxp7 - {1'b0, wx_q}) < 9'(ScreenWidth));

  // object scan geometry
  logic       tall, in_rng;
  logic [8:0] sum9, rel9;
  logic [3:0] yo;
  logic [VaW-1:0] obj_addr;
  logic [15:0] pat_raw, pat;
  assign tall   = lcdc_q[2];
  assign sum9   = {1'b0, ly_q} + 9'd16;
  assign rel9   = sum9 - {1'b0, oy_q};
  assign in_rng = (sum9 >= {1'b0, oy_q}) && (rel9 < (tall ? 9'd16 : 9'd8));
  assign yo     = oat_q[6] ? (rel9[3:0] ^ (tall ? 4'hF : 4'h7)) : rel9[3:0];
  assign obj_addr = {1'b0, ot_q[7:1], (tall ? yo[3] : ot_q[0]), yo[2:0], 1'b0};
  assign pat_raw  = {vram_rd, plo_q};
  assign pat = oat_q[5] ? {rev_byte(pat_raw[15:8]), rev_byte(pat_raw[7:0])} : pat_raw;

  // tile fetch addresses
  logic [VaW-1:0] map_addr, dat_addr;
  assign map_addr = {2'b11, fhm_q, fy_q[7:3], fx_q[7:3]};
  always_comb begin
    if (lcdc_q[4]) begin
      dat_addr = {1'b0, vram_rd, 4'b0000};
    end else begin
      dat_addr = 13'h1000 + {vram_rd[7], vram_rd, 4'b0000};
    end
    dat_addr = dat_addr | {9'd0, fy_q[2:0], 1'b0};
  end

  // line object store
  logic [8:0] odiff;
  logic       ohit;
  logic [1:0] oidx;
  assign lr_data = line_q[lr_idx];
  assign odiff   = pxp8 - {1'b0, lr_data.x};
  assign ohit    = (pxp8 >= {1'b0, lr_data.x}) && (odiff < 9'd8);
  assign oidx    = pick_index(lr_data.pattern, odiff[2:0]);

  always_comb begin
    lw_we   = 1'b0;
    lw_idx  = cnt_q;
    lw_data = '{x: ox_q, attr: oat_q, pattern: pat};
    lr_idx  = hi_q;
    unique case (state_q)
      SC_P2: lw_we = 1'b1;
      SO_LOAD: lr_idx = lo_q;
      SO_CMP: begin
        lr_idx  = hi_q;
        lw_idx  = hi_q;
        lw_data = cur_q;
        lw_we   = (lr_data.x < cur_q.x);
      end
      SO_STORE: begin
        lw_we   = 1'b1;
        lw_idx  = lo_q;
        lw_data = cur_q;
      end
      R_OBJ: lr_idx = n_q - SlotW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (lw_we) begin
      line_q[lw_idx] <= lw_data;
    end
  end

  // background shade is zero when neither the background nor the window shows
  logic [1:0] obj_col, bg_col;
  assign obj_col = pal_map(oattr_q[4] ? obp1_q : obp0_q, oi_q);
  assign bg_col  = (lcdc_q[0] || win_hit) ? pal_map(bgp_q, bi_q) : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lcdc_q <= '0; scy_q <= '0; scx_q <= '0; wy_q <= '0;
      wx_q <= '0; bgp_q <= '0; obp0_q <= '0; obp1_q <= '0;
      col_q <= '0; ly_q <= '0; bg_latch_q <= '0; win_latch_q <= '0;
      cnt_q <= '0; lo_q <= '0; hi_q <= '0; n_q <= '0; obj_q <= '0;
      oa_q <= '0; va_q <= '0; oy_q <= '0; ox_q <= '0; ot_q <= '0; oat_q <= '0;
      plo_q <= '0; cur_q <= '0; fx_q <= '0; fy_q <= '0; fhm_q <= 1'b0;
      fwin_q <= 1'b0; dark_q <= 1'b0; bi_q <= '0; oi_q <= '0; oattr_q <= '0;
      out_valid_q <= 1'b0; shade_q <= '0; ocol_q <= '0; orow_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != R_FIN)) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_index_i))
          CFG_LCDC: lcdc_q <= cfg_data_i;
          CFG_SCY:  scy_q  <= cfg_data_i;
          CFG_SCX:  scx_q  <= cfg_data_i;
          CFG_WY:   wy_q   <= cfg_data_i;
          CFG_WX:   wx_q   <= cfg_data_i;
          CFG_BGP:  bgp_q  <= cfg_data_i;
          CFG_OBP0: obp0_q <= cfg_data_i;
          CFG_OBP1: obp1_q <= cfg_data_i;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (op_e'(op_i))
              OP_LINE: begin
                ly_q    <= line_number_i;
                col_q   <= '0;
                cnt_q   <= '0;
                obj_q   <= '0;
                state_q <= SC_A0;
              end
              OP_PIXEL: state_q <= R_START;
              default: ;
            endcase
          end
        end
        SC_A0: begin
          oa_q    <= {obj_q, 2'd0};
          state_q <= SC_A1;
        end
        SC_A1: begin
          oa_q    <= {obj_q, 2'd1};
          state_q <= SC_Y;
        end
        SC_Y: begin
          oy_q    <= oam_rd;
          oa_q    <= {obj_q, 2'd2};
          state_q <= SC_X;
        end
        SC_X: begin
          ox_q    <= oam_rd;
          oa_q    <= {obj_q, 2'd3};
          state_q <= SC_T;
        end
        SC_T: begin
          ot_q    <= oam_rd;
          state_q <= SC_AT;
        end
        SC_AT: begin
          oat_q   <= oam_rd;
          state_q <= SC_CHK;
        end
        SC_CHK: begin
          if (in_rng) begin
            va_q    <= obj_addr;
            state_q <= SC_P0;
          end else begin
            obj_q   <= obj_q + ObjW'(1);
            state_q <= (obj_q == ObjW'(ObjCount - 1)) ? SO_INIT : SC_A0;
          end
        end
        SC_P0: begin
          va_q    <= va_q | VaW'(1);
          state_q <= SC_P1;
        end
        SC_P1: begin
          plo_q   <= vram_rd;
          state_q <= SC_P2;
        end
        SC_P2: begin
          cnt_q <= cnt_q + SlotW'(1);
          obj_q <= obj_q + ObjW'(1);
          if ((cnt_q == SlotW'(ObjPerLine - 1)) || (obj_q == ObjW'(ObjCount - 1))) begin
            state_q <= SO_INIT;
          end else begin
            state_q <= SC_A0;
          end
        end
        SO_INIT: begin
          lo_q    <= '0;
          state_q <= (cnt_q < SlotW'(2)) ? ST_IDLE : SO_LOAD;
        end
        SO_LOAD: begin
          cur_q   <= lr_data;
          hi_q    <= lo_q + SlotW'(1);
          state_q <= SO_CMP;
        end
        SO_CMP: begin
          if (lr_data.x < cur_q.x) begin
            cur_q <= lr_data;
          end
          if (hi_q == cnt_q - SlotW'(1)) begin
            state_q <= SO_STORE;
          end else begin
            hi_q <= hi_q + SlotW'(1);
          end
        end
        SO_STORE: begin
          lo_q    <= lo_q + SlotW'(1);
          state_q <= ((lo_q + SlotW'(2)) < cnt_q) ? SO_LOAD : ST_IDLE;
        end
        R_START: begin
          bi_q   <= '0;
          oi_q   <= '0;
          dark_q <= !lcdc_q[7];
          if (!lcdc_q[7]) begin
            state_q <= R_FIN;
          end else if (lcdc_q[0] && ((sx[2:0] == 3'd0) || (col_q == 8'd0))) begin
            fx_q    <= sx;
            fy_q    <= sy;
            fhm_q   <= lcdc_q[3];
            fwin_q  <= 1'b0;
            state_q <= F_MAP;
          end else begin
            state_q <= R_WIN;
          end
        end
        R_WIN: begin
          if (lcdc_q[0]) begin
            bi_q <= pick_index(bg_latch_q, sx[2:0]);
          end
          if (win_hit) begin
            if ((wxv[2:0] == 3'd0) || (col_q == 8'd0)) begin
              fx_q    <= wxv;
              fy_q    <= wyv;
              fhm_q   <= lcdc_q[6];
              fwin_q  <= 1'b1;
              state_q <= F_MAP;
            end else begin
              state_q <= R_WSEL;
            end
          end else begin
            state_q <= R_OBJI;
          end
        end
        R_WSEL: begin
          bi_q    <= pick_index(win_latch_q, wxv[2:0]);
          state_q <= R_OBJI;
        end
        R_OBJI: begin
          n_q     <= cnt_q;
          state_q <= (lcdc_q[1] && (cnt_q != '0)) ? R_OBJ : R_FIN;
        end
        R_OBJ: begin
          if (ohit && (oidx != 2'd0)) begin
            oi_q    <= oidx;
            oattr_q <= lr_data.attr;
          end
          n_q <= n_q - SlotW'(1);
          if (n_q == SlotW'(1)) begin
            state_q <= R_FIN;
          end
        end
        R_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            ocol_q      <= col_q;
            orow_q      <= ly_q;
            priority if (dark_q) shade_q <= 2'd0;
            else if (oi_q == 2'd0) shade_q <= bg_col;
            else if (bi_q == 2'd0) shade_q <= obj_col;
            else shade_q <= oattr_q[7] ? bg_col : obj_col;
            col_q   <= col_q + 8'd1;
            state_q <= ST_IDLE;
          end
        end
        F_MAP: begin
          va_q    <= map_addr;
          state_q <= F_MW;
        end
        F_MW: state_q <= F_TILE;
        F_TILE: begin
          va_q    <= dat_addr;
          state_q <= F_DW;
        end
        F_DW: begin
          va_q    <= va_q | VaW'(1);
          state_q <= F_LO;
        end
        F_LO: begin
          plo_q   <= vram_rd;
          state_q <= F_HI;
        end
        F_HI: begin
          if (fwin_q) begin
            win_latch_q <= {vram_rd, plo_q};
            state_q     <= R_WSEL;
          end else begin
            bg_latch_q <= {vram_rd, plo_q};
            state_q    <= R_WIN;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign shade_o     = shade_q;
  assign column_o    = ocol_q;
  assign row_o       = orow_q;

endmodule

### tb/sv/tb_tile_sprite_scanline_renderer.sv
// Self-checking testbench for the tile and sprite scanline renderer.
module tb_tile_sprite_scanline_renderer;
  timeunit 1ns;
  timeprecision 1ps;
  import tssr_pkg::*;

  typedef struct {
    op_e         op;
    logic [12:0] addr;
    logic [7:0]  data;
    logic [7:0]  line;
  } beat_t;

  typedef struct {
    logic [1:0] shade;
    logic [7:0] column;
    logic [7:0] row;
  } pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i = '0;
  logic [12:0] address_i = '0;
  logic [7:0]  write_data_i = '0;
  logic [7:0]  line_number_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  shade_o;
  logic [7:0]  column_o;
  logic [7:0]  row_o;

  tile_sprite_scanline_renderer u_top (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  beat_t  pending_beats[$];
  pixel_t expected_pixels[$];
  int     errors = 0;
  int     pixels_checked = 0;
  int     lines_started = 0;
  int     cycles = 0;
  bit     idle_en = 1'b1;
  bit     hold_req = 1'b0;
  bit     hold_done = 1'b0;
  int     hold_cnt = 0;

  // model state
  logic [7:0]  vram[VideoBytes];
  logic [7:0]  oam[OamBytes];
  logic [7:0]  slot_x[ObjPerLine];
  logic [7:0]  slot_attr[ObjPerLine];
  logic [15:0] slot_pat[ObjPerLine];
  int          slot_cnt = 0;
  logic [7:0]  cur_col = 0, cur_row = 0;
  logic [15:0] bg_latch = 0, win_latch = 0;
  logic [7:0]  regs[8] = '{default: 8'h00};

  function automatic logic [7:0] vrd(int unsigned a);
    return vram[a & (VideoBytes - 1)];
  endfunction

  function automatic logic [15:0] tile_row(bit hi_map, int unsigned x, int unsigned y);
    int unsigned map, tile, data;
    map = 'h1800 + (hi_map ? 'h400 : 0) + ((((y >> 3) << 5) + (x >> 3)) & 'h3ff);
    tile = vrd(map);
    if (regs[CFG_LCDC][4]) data = tile << 4;
    else data = ('h1000 + (((tile ^ 'h80) - 'h80) << 4)) & 'hffff;
    data += (y & 7) << 1;
    return {vrd(data + 1), vrd(data)};
  endfunction

  function automatic logic [1:0] color_of(logic [15:0] d, int unsigned tx);
    return {d[15 - tx], d[7 - tx]};
  endfunction

  function automatic logic [1:0] shade_of(logic [7:0] p, logic [1:0] idx);
    return p[2*idx +: 2];
  endfunction

  function automatic logic [7:0] flip8(logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[7 - i] = b[i];
    return r;
  endfunction

  task automatic scan_line();
    int unsigned height, y, tile, a;
    int          rel;
    logic [7:0]  attr, tx, ta;
    logic [15:0] d, tp;
    height = regs[CFG_LCDC][2] ? 16 : 8;
    slot_cnt = 0;
    for (int n = 0; n < ObjCount && slot_cnt < ObjPerLine; n++) begin
      rel = int'(cur_row) + 16 - int'(oam[4*n]);
      if (rel < 0 || rel >= int'(height)) continue;
      y = rel;
      attr = oam[4*n + 3];
      tile = oam[4*n + 2];
      if (height == 16) tile &= 'hfe;
      if (attr[6]) y ^= height - 1;
      a = (tile << 4) + (y << 1);
      d = {vrd(a + 1), vrd(a)};
      if (attr[5]) d = {flip8(d[15:8]), flip8(d[7:0])};
      slot_x[slot_cnt] = oam[4*n + 1];
      slot_attr[slot_cnt] = attr;
      slot_pat[slot_cnt] = d;
      slot_cnt++;
    end
    for (int lo = 0; lo < slot_cnt; lo++) begin
      for (int hi = lo + 1; hi < slot_cnt; hi++) begin
        if (slot_x[hi] < slot_x[lo]) begin
          tx = slot_x[lo]; ta = slot_attr[lo]; tp = slot_pat[lo];
          slot_x[lo] = slot_x[hi]; slot_attr[lo] = slot_attr[hi];
          slot_pat[lo] = slot_pat[hi];
          slot_x[hi] = tx; slot_attr[hi] = ta; slot_pat[hi] = tp;
        end
      end
    end
  endtask

  function automatic logic [1:0] next_shade();
    int unsigned px, ly, sx, sy, tx, wx, wy;
    int          otx;
    logic [1:0]  bg_idx, bg_sh, ob_idx, ob_sh, idx;
    bit          ob_front;
    px = cur_col; ly = cur_row;
    bg_idx = 0; bg_sh = 0; ob_idx = 0; ob_sh = 0; ob_front = 0;
    if (!regs[CFG_LCDC][7]) return 2'd0;
    if (regs[CFG_LCDC][0]) begin
      sy = (ly + regs[CFG_SCY]) & 255;
      sx = (px + regs[CFG_SCX]) & 255;
      tx = sx & 7;
      if (tx == 0 || px == 0) bg_latch = tile_row(regs[CFG_LCDC][3], sx, sy);
      bg_idx = color_of(bg_latch, tx);
      bg_sh = shade_of(regs[CFG_BGP], bg_idx);
    end
    if (regs[CFG_LCDC][5]) begin
      wy = ly - int'(regs[CFG_WY]);
      wx = px + 7 - int'(regs[CFG_WX]);
      if (wy < WinLines && wx < ScreenWidth) begin
        tx = wx & 7;
        if (tx == 0 || px == 0) win_latch = tile_row(regs[CFG_LCDC][6], wx, wy);
        bg_idx = color_of(win_latch, tx);
        bg_sh = shade_of(regs[CFG_BGP], bg_idx);
      end
    end
    if (regs[CFG_LCDC][1]) begin
      for (int n = slot_cnt - 1; n >= 0; n--) begin
        otx = int'(px) + 8 - int'(slot_x[n]);
        if (otx < 0 || otx > 7) continue;
        idx = color_of(slot_pat[n], otx);
        if (idx == 0) continue;
        ob_sh = shade_of(slot_attr[n][4] ? regs[CFG_OBP1] : regs[CFG_OBP0], idx);
        ob_idx = idx;
        ob_front = !slot_attr[n][7];
      end
    end
    if (ob_idx == 0) return bg_sh;
    if (bg_idx == 0) return ob_sh;
    return ob_front ? ob_sh : bg_sh;
  endfunction

  task automatic apply_beat(beat_t b);
    pixel_t p;
    case (b.op)
      OP_VRAM_WR: vram[b.addr] = b.data;
      OP_OAM_WR:  if (b.addr < OamBytes) oam[b.addr] = b.data;
      OP_LINE: begin
        cur_row = b.line;
        cur_col = 0;
        scan_line();
      end
      OP_PIXEL: begin
        p.shade = next_shade();
        p.column = cur_col;
        p.row = cur_row;
        expected_pixels.push_back(p);
        cur_col++;
      end
    endcase
  endtask

  // driver
  always @(posedge clk_i) begin
    beat_t b;
    bit    take;
    take = in_valid_i && in_ready_o;
    if (take) apply_beat('{op_e'(op_i), address_i, write_data_i, line_number_i});
    if (!in_valid_i || take) begin
      if (pending_beats.size() > 0 && !(idle_en && $urandom_range(99) < 15)) begin
        b = pending_beats.pop_front();
        op_i <= b.op;
        address_i <= b.addr;
        write_data_i <= b.data;
        line_number_i <= b.line;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver with one long hold-off
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= 3000;
      out_ready_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !(idle_en && $urandom_range(99) < 15);
    end
  end

  task automatic report(string what, int got, int want);
    errors++;
    $display("MISMATCH %s: got %0d want %0d (pixel %0d)", what, got, want, pixels_checked);
  endtask

  // monitor
  always @(posedge clk_i) begin
    pixel_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        report("unexpected beat, column", column_o, -1);
      end else begin
        e = expected_pixels.pop_front();
        if (shade_o !== e.shade) report("shade", shade_o, e.shade);
        if (column_o !== e.column) report("column", column_o, e.column);
        if (row_o !== e.row) report("row", row_o, e.row);
      end
      pixels_checked++;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 1500000) begin
      $display("timeout waiting for pixels");
      $display("tb_tile_sprite_scanline_renderer NOT OK");
      $finish;
    end
  end

  task automatic push(op_e o, logic [12:0] a, logic [7:0] d, logic [7:0] l);
    pending_beats.push_back('{o, a, d, l});
  endtask

  task automatic push_line(logic [7:0] l, int npix);
    push(OP_LINE, 13'($urandom), 8'($urandom), l);
    lines_started++;
    for (int i = 0; i < npix; i++) push(OP_PIXEL, 13'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    while (pending_beats.size() > 0 || in_valid_i || expected_pixels.size() > 0)
      @(posedge clk_i);
    repeat (1500) @(posedge clk_i);
  endtask

  task automatic set_reg(cfg_e idx, logic [7:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    regs[idx] = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // tile numbers 0..7 and 0xf8..0xff keep pattern reads inside 0x0000-0x007f and
  // 0x0f80-0x107f in both tile data modes
  function automatic logic [7:0] pick_tile();
    logic [3:0] r;
    r = 4'($urandom);
    return r[3] ? {5'b11111, r[2:0]} : {5'b00000, r[2:0]};
  endfunction

  task automatic fill_vram(int unsigned base, int unsigned len, bit tiles);
    for (int unsigned i = 0; i < len; i++)
      push(OP_VRAM_WR, 13'(base + i), tiles ? pick_tile() : 8'($urandom), 8'($urandom));
  endtask

  // objects clustered around one line so scans find many hits
  task automatic load_objects(logic [7:0] target);
    for (int n = 0; n < ObjCount; n++) begin
      push(OP_OAM_WR, 13'(4*n), $urandom_range(3) == 0 ? 8'($urandom)
           : 8'(target + 16 - $urandom_range(15)), 8'h00);
      push(OP_OAM_WR, 13'(4*n + 1), 8'($urandom_range(175)), 8'h00);
      push(OP_OAM_WR, 13'(4*n + 2), pick_tile(), 8'h00);
      push(OP_OAM_WR, 13'(4*n + 3), 8'($urandom), 8'h00);
    end
  endtask

  task automatic move_objects(logic [7:0] target);
    for (int n = 0; n < ObjCount; n++)
      push(OP_OAM_WR, 13'(4*n), $urandom_range(3) == 0 ? 8'($urandom)
           : 8'(target + 16 - $urandom_range(15)), 8'h00);
  endtask

  initial begin
    logic [7:0] target;
    logic [7:0] v;
    foreach (vram[i]) vram[i] = 0;
    foreach (oam[i]) oam[i] = 0;
    foreach (slot_x[i]) begin
      slot_x[i] = 0; slot_attr[i] = 0; slot_pat[i] = 0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // display off: pixels before any memory traffic read nothing
    push(OP_PIXEL, 13'h1fff, 8'hff, 8'hff);
    push(OP_PIXEL, 13'h0000, 8'h00, 8'h00);
    // tile data areas and map rows 0..3 of both maps; lines and scrolls keep reads there
    fill_vram('h0000, 'h80, 1'b0);
    fill_vram('h0f80, 'h100, 1'b0);
    fill_vram('h1800, 'h80, 1'b1);
    fill_vram('h1c00, 'h80, 1'b1);
    load_objects(8'd0);
    push(OP_OAM_WR, 13'd160, 8'h5a, 8'h00);
    push(OP_OAM_WR, 13'h1fff, 8'hff, 8'h00);
    push(OP_VRAM_WR, 13'h1fff, 8'h00, 8'h00);
    push_line(8'd0, 3);
    push_line(8'd255, 3);
    drain();
    // every feature on, extreme settings
    set_reg(CFG_LCDC, 8'hff);
    set_reg(CFG_SCY, 8'hff);
    set_reg(CFG_SCX, 8'hff);
    set_reg(CFG_WY, 8'h00);
    set_reg(CFG_WX, 8'h00);
    set_reg(CFG_BGP, 8'he4);
    set_reg(CFG_OBP0, 8'h1b);
    set_reg(CFG_OBP1, 8'hff);
    move_objects(8'd1);
    push_line(8'd1, 8);
    push_line(8'd8, 6);
    // column wraps past 255
    push_line(8'd2, 262);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      idle_en = (ph != 1);
      target = (ph == 3) ? 8'($urandom_range(24)) : 8'($urandom);
      for (int r = 0; r < 8; r++) begin
        v = 8'($urandom);
        if (r == CFG_LCDC) v = (ph == 2) ? 8'h7f : (v | 8'h80);
        if (r == CFG_SCY) v = 8'($urandom_range(24) - target);
        if (r == CFG_WY) v = $urandom_range(1) ? 8'(target - $urandom_range(24))
                                               : 8'(target + 8 + $urandom_range(60));
        if (ph == 3) v = (r == CFG_LCDC) ? 8'h81 : 8'h00;
        if (ph == 4 && r == CFG_WX) v = $urandom_range(1) ? 8'd166 : 8'd7;
        set_reg(cfg_e'(r), v);
      end
      move_objects(target);
      for (int i = 0; i < 4; i++)
        push(OP_VRAM_WR, 13'($urandom_range(127)), 8'($urandom), 8'h00);
      if (ph == 5) hold_req = 1'b1;
      for (int k = 0; k < 4; k++)
        push_line(8'(target + $urandom_range(7)), $urandom_range(6, 16));
      drain();
    end
    idle_en = 1'b1;
    repeat (100) @(posedge clk_i);
    $display("checked %0d pixels over %0d lines: display off, scroll and column wrap,",
             pixels_checked, lines_started);
    $display("window edges, tall and flipped objects, and a long output stall");
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("tb_tile_sprite_scanline_renderer OK");
    end else begin
      $display("tb_tile_sprite_scanline_renderer NOT OK");
    end
    $finish;
  end

endmodule
